// ===== hw/rtl/xbp_pkg.sv =====
// Package for the XOR/bend pattern pixel generator.
// Field widths, register indexes, pattern constants and the divider step.
// No dependencies.
`default_nettype none

package xbp_pkg;

  localparam int unsigned POS_X_W      = 7;
  localparam int unsigned POS_Y_W      = 5;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam int unsigned BEND_PERIOD  = 3000;
  localparam int unsigned BEND_MID     = 32;
  localparam int unsigned BEND_SCALE   = 7;
  localparam int unsigned BEND_OFFSET  = 16;
  localparam logic [7:0]  BLUE_MASK    = 8'h88;

  // floor(2^32 / BEND_PERIOD)
  localparam int unsigned RECIP_SHIFT  = 32;
  localparam logic [20:0] BEND_RECIP   = 21'((64'd1 << RECIP_SHIFT) / 64'(BEND_PERIOD));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_XOR_MASK = 3'd1,
    CFG_XOR_GAIN = 3'd2,
    CFG_ROW_MULT = 3'd3,
    CFG_COL_MULT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MODE_XOR  = 1'b0,
    MODE_BEND = 1'b1
  } pattern_mode_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [3:0] quo;
  } div_step_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Four restoring-division steps; rem stays below dvs.
  function automatic div_step_t div_step4(input logic [7:0] rem, input logic [3:0] bits,
                                          input logic [7:0] dvs);
    logic [8:0] acc;
    logic [7:0] r;
    div_step_t  res;
    r = rem;
    res.quo = '0;
    for (int i = 3; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, dvs}) begin
        acc = acc - {1'b0, dvs};
        res.quo[i] = 1'b1;
      end
      r = acc[7:0];
    end
    res.rem = r;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xbp_in_if.sv =====
// Input channel of the pattern pixel generator: pixel position and frame number.
// Depends on xbp_pkg.
`default_nettype none

interface xbp_in_if;
  import xbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, output pos_x, output pos_y, output frame_number, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input frame_number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xbp_out_if.sv =====
// Result channel of the pattern pixel generator: one RGB pixel per item.
// Depends on xbp_pkg.
`default_nettype none

interface xbp_out_if;
  import xbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xor_bend_pattern_pixel_generator_unit.sv =====
// Top level of the XOR/bend pattern pixel generator, a seven-stage pipeline.
// Depends on xbp_pkg, xbp_in_if and xbp_out_if.
`default_nettype none

// Takes one pixel item (pos_x, pos_y, frame_number) per clock and returns its
// red, green and blue through stages s1 to s7, one item per cycle while out_px
// is ready. The depth is set by the bend path: a reciprocal multiply and a fold
// that reduce the frame number modulo 3000, three stages of a 4-bit-per-stage
// divider for 16f/(x+16) and 16f/(y+16), and the output register. Each stage
// holds only while its successor is full, so bubbles close up under a stall.
// The user writes registers via cfg_we/cfg_index/cfg_data only while no
// item is in flight (not enforced); writes to unknown indexes are dropped.
module xor_bend_pattern_pixel_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  xbp_in_if.sink                          in_px,
  xbp_out_if.source                       out_px
);
  import xbp_pkg::*;

  logic        mode_r;
  logic [15:0] xor_mask_r;
  logic [3:0]  xor_gain_r;
  logic [3:0]  row_mult_r;
  logic [3:0]  col_mult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_XOR;
      xor_mask_r <= 16'd4;
      xor_gain_r <= 4'd7;
      row_mult_r <= 4'd2;
      col_mult_r <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_data[0];
        CFG_XOR_MASK: xor_mask_r <= cfg_data;
        CFG_XOR_GAIN: xor_gain_r <= cfg_data[3:0];
        CFG_ROW_MULT: row_mult_r <= cfg_data[3:0];
        CFG_COL_MULT: col_mult_r <= cfg_data[3:0];
        default:      ;
      endcase
    end
  end

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !s7_v_r || out_px.ready;
  assign en6 = !s6_v_r || en7;
  assign en5 = !s5_v_r || en6;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_px.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_px.valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
      if (en5) s5_v_r <= s4_v_r;
      if (en6) s6_v_r <= s5_v_r;
      if (en7) s7_v_r <= s6_v_r;
    end
  end

  // Stage 1: quotient estimate of frame / 3000, low by at most one.
  logic [52:0]        qe_prod;
  logic [POS_X_W-1:0] s1_x_r;
  logic [POS_Y_W-1:0] s1_y_r;
  logic [12:0]        s1_frm_r;
  logic [20:0]        s1_qe_r;

  assign qe_prod = 53'(in_px.frame_number) * 53'(BEND_RECIP);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_x_r   <= in_px.pos_x;
      s1_y_r   <= in_px.pos_y;
      s1_frm_r <= in_px.frame_number[12:0];
      s1_qe_r  <= qe_prod[52:32];
    end
  end

  // Stage 2: remainder below twice the period; XOR pattern terms.
  logic [12:0] qmul_lo;
  logic [7:0]  x8, y8, frm8, sum8, dif8, xo8, mask8;
  logic [11:0] xr_full, xg_full, xb_full;
  logic [POS_X_W-1:0] s2_x_r;
  logic [POS_Y_W-1:0] s2_y_r;
  logic [12:0]        s2_rem_r;
  rgb_t               s2_xor_r;

  assign qmul_lo = s1_qe_r[12:0] * 13'(BEND_PERIOD);
  assign x8      = 8'(s1_x_r);
  assign y8      = 8'(s1_y_r);
  assign frm8    = s1_frm_r[7:0];
  assign sum8    = x8 + y8 + frm8;
  assign dif8    = x8 - y8 - frm8;
  assign xo8     = x8 ^ y8;
  assign mask8   = xor_mask_r[7:0];
  assign xr_full = 12'(sum8 & mask8) * 12'(xor_gain_r);
  assign xg_full = 12'(dif8 & mask8) * 12'(xor_gain_r);
  assign xb_full = 12'(xo8 & mask8) * 12'(xor_gain_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_x_r         <= s1_x_r;
      s2_y_r         <= s1_y_r;
      s2_rem_r       <= s1_frm_r - qmul_lo;
      s2_xor_r.red   <= xr_full[7:0];
      s2_xor_r.green <= xg_full[7:0];
      s2_xor_r.blue  <= xb_full[7:0];
    end
  end

  // Stage 3: fold to frame mod 3000; form the two divisors.
  logic [12:0]        rem_fold;
  logic [POS_X_W-1:0] s3_x_r;
  logic [POS_Y_W-1:0] s3_y_r;
  logic [11:0]        s3_f_r;
  logic [7:0]         s3_div_a_r, s3_div_b_r;
  rgb_t               s3_xor_r;

  assign rem_fold = (s2_rem_r >= 13'(BEND_PERIOD)) ? s2_rem_r - 13'(BEND_PERIOD) : s2_rem_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
      s3_f_r     <= rem_fold[11:0];
      s3_div_a_r <= 8'(s2_x_r) + 8'(BEND_OFFSET);
      s3_div_b_r <= 8'(s2_y_r) + 8'(BEND_OFFSET);
      s3_xor_r   <= s2_xor_r;
    end
  end

  // Stages 4 to 6: divide 16f by each divisor, four quotient bits a stage.
  div_step_t          st4_a, st4_b, st5_a, st5_b, st6_a, st6_b;
  logic [POS_X_W-1:0] s4_x_r, s5_x_r, s6_x_r;
  logic [POS_Y_W-1:0] s4_y_r, s5_y_r, s6_y_r;
  logic [3:0]         s4_flo_r;
  logic [7:0]         s4_div_a_r, s4_div_b_r, s5_div_a_r, s5_div_b_r;
  logic [7:0]         s4_rem_a_r, s4_rem_b_r, s5_rem_a_r, s5_rem_b_r;
  logic [3:0]         s4_qa_r, s4_qb_r;
  logic [7:0]         s5_qa_r, s5_qb_r;
  logic [11:0]        s6_qa_r, s6_qb_r;
  rgb_t               s4_xor_r, s5_xor_r, s6_xor_r;

  assign st4_a = div_step4(8'(s3_f_r[11:8]), s3_f_r[7:4], s3_div_a_r);
  assign st4_b = div_step4(8'(s3_f_r[11:8]), s3_f_r[7:4], s3_div_b_r);
  assign st5_a = div_step4(s4_rem_a_r, s4_flo_r, s4_div_a_r);
  assign st5_b = div_step4(s4_rem_b_r, s4_flo_r, s4_div_b_r);
  assign st6_a = div_step4(s5_rem_a_r, 4'd0, s5_div_a_r);
  assign st6_b = div_step4(s5_rem_b_r, 4'd0, s5_div_b_r);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_x_r     <= s3_x_r;
      s4_y_r     <= s3_y_r;
      s4_flo_r   <= s3_f_r[3:0];
      s4_div_a_r <= s3_div_a_r;
      s4_div_b_r <= s3_div_b_r;
      s4_rem_a_r <= st4_a.rem;
      s4_rem_b_r <= st4_b.rem;
      s4_qa_r    <= st4_a.quo;
      s4_qb_r    <= st4_b.quo;
      s4_xor_r   <= s3_xor_r;
    end
    if (en5) begin
      s5_x_r     <= s4_x_r;
      s5_y_r     <= s4_y_r;
      s5_div_a_r <= s4_div_a_r;
      s5_div_b_r <= s4_div_b_r;
      s5_rem_a_r <= st5_a.rem;
      s5_rem_b_r <= st5_b.rem;
      s5_qa_r    <= {s4_qa_r, st5_a.quo};
      s5_qb_r    <= {s4_qb_r, st5_b.quo};
      s5_xor_r   <= s4_xor_r;
    end
    if (en6) begin
      s6_x_r     <= s5_x_r;
      s6_y_r     <= s5_y_r;
      s6_qa_r    <= {s5_qa_r, st6_a.quo};
      s6_qb_r    <= {s5_qb_r, st6_b.quo};
      s6_xor_r   <= s5_xor_r;
    end
  end

  // Stage 7: triangle terms, masks and pattern select into the output register.
  logic [8:0] row_prod, col_prod;
  logic [5:0] v1, v2, d1, d2;
  logic [7:0] t1, t2, row_mask, col_mask;
  rgb_t       bend_rgb;
  rgb_t       s7_rgb_r;

  assign row_prod = 9'(row_mult_r) * 9'(s6_y_r);
  assign col_prod = 9'(col_mult_r) * 9'(s6_x_r);
  assign v1       = row_prod[5:0] + s6_qa_r[5:0];
  assign v2       = col_prod[5:0] + s6_qb_r[5:0];
  assign d1       = (v1 >= 6'(BEND_MID)) ? v1 - 6'(BEND_MID) : 6'(BEND_MID) - v1;
  assign d2       = (v2 >= 6'(BEND_MID)) ? v2 - 6'(BEND_MID) : 6'(BEND_MID) - v2;
  assign t1       = 8'(d1) * 8'(BEND_SCALE);
  assign t2       = 8'(d2) * 8'(BEND_SCALE);
  assign row_mask = {row_mult_r[2:0], 5'd0} - 8'd1;
  assign col_mask = {col_mult_r[2:0], 5'd0} - 8'd1;

  assign bend_rgb.red   = t1 & row_mask;
  assign bend_rgb.green = t2 & col_mask;
  assign bend_rgb.blue  = (t1 ^ t2) & BLUE_MASK;

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_rgb_r <= (mode_r == MODE_BEND) ? bend_rgb : s6_xor_r;
    end
  end

  assign out_px.valid = s7_v_r;
  assign out_px.red   = s7_rgb_r.red;
  assign out_px.green = s7_rgb_r.green;
  assign out_px.blue  = s7_rgb_r.blue;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_px.valid && in_px.ready |=> s1_v_r)
    else $error("accepted item missing from first stage");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> s2_rem_r < 13'(2 * BEND_PERIOD))
    else $error("quotient estimate off by more than one");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_rem_a_r < s4_div_a_r) && (s4_rem_b_r < s4_div_b_r))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
